/* rtl/core/kvcfg_pkg.sv */
// Shared types and constants for the key/value configuration text parser.
`default_nettype none
package kvcfg_pkg;

   localparam int DEF_MAX_TEXT_LEN = 63;
   localparam int DEF_MAX_ENTRIES  = 64;
   localparam int SLOTS            = 3;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] KIND_NAME   = 3'd0;
   localparam logic [2:0] KIND_VALUE  = 3'd1;
   localparam logic [2:0] KIND_ACCEPT = 3'd2;
   localparam logic [2:0] KIND_REJECT = 3'd3;
   localparam logic [2:0] KIND_EOF    = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [7:0] result_byte;
      logic [6:0] entry_number;
      logic       final_of_run;
   } rsp_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic [6:0] number;
   } slot_type;

   typedef struct packed {
      logic [1:0]           count;
      slot_type [SLOTS-1:0] slot;
   } bundle_type;

endpackage
`default_nettype wire

/* rtl/core/key_value_config_text_parser_top.sv */
// Top level of the key/value configuration text parser.
//
//   channel   direction  payload                                   handshake
//   req_      in         text_byte, end_of_text                    req_valid / req_ready
//   rsp_      out        result_kind, result_byte, entry_number,   rsp_valid / rsp_ready
//                        final_of_run
//
// One text byte is taken per cycle while the four-bundle queue has room;
// each byte yields zero to three result beats, one beat per cycle on rsp_ while rsp_ready is high.
// The output side therefore sets the sustained rate.
// Reset is synchronous and returns the parser to idle with counts cleared.
// A stalled rsp_ side backs up the queue, then drops req_ready.
`default_nettype none
module key_value_config_text_parser_top #(
   parameter int MAX_TEXT_LEN = kvcfg_pkg::DEF_MAX_TEXT_LEN,
   parameter int MAX_ENTRIES  = kvcfg_pkg::DEF_MAX_ENTRIES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire kvcfg_pkg::req_type  req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output kvcfg_pkg::rsp_type       rsp_payload
);
   import kvcfg_pkg::*;

   logic       queue_full, push, pop, head_valid;
   bundle_type push_bundle, head_bundle;

   kvcfg_front #(
      .MAX_TEXT_LEN(MAX_TEXT_LEN),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .queue_full (queue_full),
      .push       (push),
      .push_bundle(push_bundle)
   );

   kvcfg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_bundle(push_bundle),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_bundle(head_bundle)
   );

   kvcfg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_bundle(head_bundle),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire

/* rtl/core/kvcfg_front.sv */
// Front end: parse one text byte per beat and build the bundle of results it causes.
`default_nettype none
module kvcfg_front #(
   parameter int MAX_TEXT_LEN = kvcfg_pkg::DEF_MAX_TEXT_LEN,
   parameter int MAX_ENTRIES  = kvcfg_pkg::DEF_MAX_ENTRIES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire kvcfg_pkg::req_type     req_payload,
   input  wire logic                   queue_full,
   output logic                        push,
   output kvcfg_pkg::bundle_type       push_bundle
);
   import kvcfg_pkg::*;

   localparam int LEN_W = $clog2(MAX_TEXT_LEN + 1);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [3:0] PH_IDLE        = 4'd0;
   localparam logic [3:0] PH_NAME        = 4'd1;
   localparam logic [3:0] PH_PRE_EQ      = 4'd2;
   localparam logic [3:0] PH_PRE_BRACKET = 4'd3;
   localparam logic [3:0] PH_PRE_VALUE   = 4'd4;
   localparam logic [3:0] PH_VALUE       = 4'd5;
   localparam logic [3:0] PH_DROP2       = 4'd6;
   localparam logic [3:0] PH_DROP1       = 4'd7;
   localparam logic [3:0] PH_LINE        = 4'd8;

   logic [3:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   bundle_type       bundle;
   logic [1:0]       n;
   logic [7:0]       c;
   logic             is_ws, is_name, accept;

   assign c         = req_payload.text_byte;
   assign is_ws     = c inside {8'h20, 8'h0A, 8'h0D, 8'h09};
   assign is_name   = c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      bundle   = '0;
      n        = 2'd0;
      case (phase_ff)
         PH_IDLE: begin
            if (!is_ws) begin
               len_in = '0;
               if (c == 8'h23) begin
                  phase_in = PH_LINE;
               end else if (is_name) begin
                  bundle.slot[n] = '{KIND_NAME, c, 7'(cnt_in)};
                  n = n + 2'd1;
                  len_in = len_in + 1'b1;
                  phase_in = (len_in >= LEN_W'(MAX_TEXT_LEN)) ? PH_PRE_EQ : PH_NAME;
               end else if (c == 8'h3D) begin
                  phase_in = PH_PRE_BRACKET;
               end else begin
                  bundle.slot[n] = '{KIND_REJECT, 8'h00, 7'(cnt_in)};
                  n = n + 2'd1;
                  phase_in = PH_LINE;
               end
            end
         end
         PH_NAME: begin
            if (is_name) begin
               bundle.slot[n] = '{KIND_NAME, c, 7'(cnt_in)};
               n = n + 2'd1;
               len_in = len_in + 1'b1;
               phase_in = (len_in >= LEN_W'(MAX_TEXT_LEN)) ? PH_PRE_EQ : PH_NAME;
            end else if (is_ws) begin
               phase_in = PH_PRE_EQ;
            end else if (c == 8'h3D) begin
               phase_in = PH_PRE_BRACKET;
            end else begin
               bundle.slot[n] = '{KIND_REJECT, 8'h00, 7'(cnt_in)};
               n = n + 2'd1;
               phase_in = PH_LINE;
            end
         end
         PH_PRE_EQ: begin
            if (!is_ws) begin
               if (c == 8'h3D) begin
                  phase_in = PH_PRE_BRACKET;
               end else begin
                  bundle.slot[n] = '{KIND_REJECT, 8'h00, 7'(cnt_in)};
                  n = n + 2'd1;
                  phase_in = PH_LINE;
               end
            end
         end
         PH_PRE_BRACKET: begin
            if (!is_ws) begin
               if (c == 8'h5B) begin
                  len_in = '0;
                  phase_in = PH_PRE_VALUE;
               end else begin
                  bundle.slot[n] = '{KIND_REJECT, 8'h00, 7'(cnt_in)};
                  n = n + 2'd1;
                  phase_in = PH_LINE;
               end
            end
         end
         PH_PRE_VALUE, PH_VALUE: begin
            if (!(phase_ff == PH_PRE_VALUE && is_ws)) begin
               if (c == 8'h5D) begin
                  if (cnt_in < CNT_W'(MAX_ENTRIES)) begin
                     bundle.slot[n] = '{KIND_ACCEPT, 8'h00, 7'(cnt_in)};
                     cnt_in = cnt_in + 1'b1;
                  end else begin
                     bundle.slot[n] = '{KIND_REJECT, 8'h00, 7'(cnt_in)};
                  end
                  n = n + 2'd1;
                  phase_in = PH_DROP1;
               end else begin
                  bundle.slot[n] = '{KIND_VALUE, c, 7'(cnt_in)};
                  n = n + 2'd1;
                  len_in = len_in + 1'b1;
                  if (len_in >= LEN_W'(MAX_TEXT_LEN)) begin
                     if (cnt_in < CNT_W'(MAX_ENTRIES)) begin
                        bundle.slot[n] = '{KIND_ACCEPT, 8'h00, 7'(cnt_in)};
                        cnt_in = cnt_in + 1'b1;
                     end else begin
                        bundle.slot[n] = '{KIND_REJECT, 8'h00, 7'(cnt_in)};
                     end
                     n = n + 2'd1;
                     phase_in = PH_DROP2;
                  end else begin
                     phase_in = PH_VALUE;
                  end
               end
            end
         end
         PH_DROP2: phase_in = PH_DROP1;
         PH_DROP1: phase_in = PH_IDLE;
         default: begin
            phase_in = (c == 8'h0A) ? PH_IDLE : PH_LINE;
         end
      endcase

      if (req_payload.end_of_text) begin
         if (phase_in == PH_NAME || phase_in == PH_PRE_EQ || phase_in == PH_PRE_BRACKET) begin
            bundle.slot[n] = '{KIND_REJECT, 8'h00, 7'(cnt_in)};
            n = n + 2'd1;
         end else if (phase_in == PH_PRE_VALUE || phase_in == PH_VALUE) begin
            if (cnt_in < CNT_W'(MAX_ENTRIES)) begin
               bundle.slot[n] = '{KIND_ACCEPT, 8'h00, 7'(cnt_in)};
               cnt_in = cnt_in + 1'b1;
            end else begin
               bundle.slot[n] = '{KIND_REJECT, 8'h00, 7'(cnt_in)};
            end
            n = n + 2'd1;
         end
         bundle.slot[n] = '{KIND_EOF, 8'h00, 7'(cnt_in)};
         n = n + 2'd1;
         phase_in = PH_IDLE;
         len_in   = '0;
         cnt_in   = '0;
      end
      bundle.count = n;
   end

   assign push        = accept && (n != 2'd0);
   assign push_bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         len_ff   <= '0;
         cnt_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/kvcfg_queue.sv */
// Short bundle queue between the parsing front end and the result back end.
`default_nettype none
module kvcfg_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire kvcfg_pkg::bundle_type  push_bundle,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        head_valid,
   output kvcfg_pkg::bundle_type       head_bundle
);
   import kvcfg_pkg::*;

   bundle_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   used_ff, used_in;
   logic              do_push, do_pop;

   assign full        = (used_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid  = (used_ff != '0);
   assign head_bundle = mem_ff[rd_ptr_ff];
   assign do_push     = push && !full;
   assign do_pop      = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      used_in   = used_ff;
      if (do_push && !do_pop) begin
         used_in = used_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         used_in = used_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/kvcfg_back.sv */
// Back end: step through the head bundle and drive one result beat per slot.
`default_nettype none
module kvcfg_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire kvcfg_pkg::bundle_type  head_bundle,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output kvcfg_pkg::rsp_type          rsp_payload
);
   import kvcfg_pkg::*;

   logic [1:0] idx_ff, idx_in;
   slot_type   cur;
   logic       last_slot, beat;

   assign cur       = head_bundle.slot[idx_ff];
   assign last_slot = (idx_ff == head_bundle.count - 2'd1);
   assign rsp_valid = head_valid;
   assign beat      = rsp_valid && rsp_ready;
   assign pop       = beat && last_slot;

   assign rsp_payload.result_kind  = cur.kind;
   assign rsp_payload.result_byte  = cur.data;
   assign rsp_payload.entry_number = cur.number;
   assign rsp_payload.final_of_run = last_slot;

   always_comb begin
      idx_in = idx_ff;
      if (beat) begin
         idx_in = last_slot ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

/* verif/kv_parse_checker.sv */
// Result checker for the key/value text parser: predicts every result beat and compares.
module kv_parse_checker #(
   parameter int MAX_TEXT_LEN = kvcfg_pkg::DEF_MAX_TEXT_LEN,
   parameter int MAX_ENTRIES  = kvcfg_pkg::DEF_MAX_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  kvcfg_pkg::req_type req_payload,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  kvcfg_pkg::rsp_type rsp_payload,
   output int                 mismatch_count,
   output int                 results_outstanding
);

   import kvcfg_pkg::*;

   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_NAME,
      SCAN_PRE_EQ,
      SCAN_PRE_BRACKET,
      SCAN_PRE_VALUE,
      SCAN_VALUE,
      SCAN_SKIP2,
      SCAN_SKIP1,
      SCAN_LINE
   } scan_phase_e;

   localparam logic [7:0] CH_EQ     = "=";
   localparam logic [7:0] CH_LBRACK = "[";
   localparam logic [7:0] CH_RBRACK = "]";
   localparam logic [7:0] CH_HASH   = "#";
   localparam logic [7:0] CH_LF     = 8'h0A;

   scan_phase_e phase;
   int unsigned text_len;
   int unsigned accepted_count;
   int          step_results;
   int          error_total;
   rsp_type     expected_q[$];
   rsp_type     want;

   function automatic bit is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
   endfunction

   function automatic bit is_name_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic void post_result(input logic [2:0] kind, input logic [7:0] data);
      rsp_type r;
      r.result_kind  = kind;
      r.result_byte  = data;
      r.entry_number = 7'(accepted_count);
      r.final_of_run = 1'b0;
      expected_q.push_back(r);
      step_results++;
   endfunction

   function automatic void close_entry();
      if (accepted_count < MAX_ENTRIES) begin
         post_result(KIND_ACCEPT, 8'h00);
         accepted_count++;
      end else begin
         post_result(KIND_REJECT, 8'h00);
      end
   endfunction

   function automatic void take_name_char(input logic [7:0] c);
      post_result(KIND_NAME, c);
      text_len++;
      phase = (text_len >= MAX_TEXT_LEN) ? SCAN_PRE_EQ : SCAN_NAME;
   endfunction

   function automatic void take_value_char(input logic [7:0] c);
      post_result(KIND_VALUE, c);
      text_len++;
      if (text_len >= MAX_TEXT_LEN) begin
         close_entry();
         phase = SCAN_SKIP2;
      end else begin
         phase = SCAN_VALUE;
      end
   endfunction

   function automatic void flag_syntax_error();
      post_result(KIND_REJECT, 8'h00);
      phase = SCAN_LINE;
   endfunction

   function automatic void predict_text_byte(input req_type b);
      logic [7:0] c;
      rsp_type    last;
      c = b.text_byte;
      step_results = 0;
      case (phase)
         SCAN_IDLE: begin
            if (!is_blank(c)) begin
               text_len = 0;
               if (c == CH_HASH) phase = SCAN_LINE;
               else if (is_name_char(c)) take_name_char(c);
               else if (c == CH_EQ) phase = SCAN_PRE_BRACKET;
               else flag_syntax_error();
            end
         end
         SCAN_NAME: begin
            if (is_name_char(c)) take_name_char(c);
            else if (is_blank(c)) phase = SCAN_PRE_EQ;
            else if (c == CH_EQ) phase = SCAN_PRE_BRACKET;
            else flag_syntax_error();
         end
         SCAN_PRE_EQ: begin
            if (!is_blank(c)) begin
               if (c == CH_EQ) phase = SCAN_PRE_BRACKET;
               else flag_syntax_error();
            end
         end
         SCAN_PRE_BRACKET: begin
            if (!is_blank(c)) begin
               if (c == CH_LBRACK) begin
                  text_len = 0;
                  phase = SCAN_PRE_VALUE;
               end else begin
                  flag_syntax_error();
               end
            end
         end
         SCAN_PRE_VALUE, SCAN_VALUE: begin
            if (!(phase == SCAN_PRE_VALUE && is_blank(c))) begin
               if (c == CH_RBRACK) begin
                  close_entry();
                  phase = SCAN_SKIP1;
               end else begin
                  take_value_char(c);
               end
            end
         end
         SCAN_SKIP2: phase = SCAN_SKIP1;
         SCAN_SKIP1: phase = SCAN_IDLE;
         default: phase = (c == CH_LF) ? SCAN_IDLE : SCAN_LINE;
      endcase
      if (b.end_of_text) begin
         if (phase == SCAN_NAME || phase == SCAN_PRE_EQ || phase == SCAN_PRE_BRACKET)
            post_result(KIND_REJECT, 8'h00);
         else if (phase == SCAN_PRE_VALUE || phase == SCAN_VALUE)
            close_entry();
         post_result(KIND_EOF, 8'h00);
         phase = SCAN_IDLE;
         text_len = 0;
         accepted_count = 0;
      end
      if (step_results > 0) begin
         last = expected_q.pop_back();
         last.final_of_run = 1'b1;
         expected_q.push_back(last);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         phase = SCAN_IDLE;
         text_len = 0;
         accepted_count = 0;
         error_total = 0;
      end else begin
         if (req_valid && req_ready) predict_text_byte(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result beat: expected none, actual %h", $time,
                        rsp_payload);
               error_total++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload.result_kind != want.result_kind) begin
                  $display("%0t result_kind: expected %0d, actual %0d", $time,
                           want.result_kind, rsp_payload.result_kind);
                  error_total++;
               end
               if (rsp_payload.result_byte != want.result_byte) begin
                  $display("%0t result_byte: expected %h, actual %h", $time,
                           want.result_byte, rsp_payload.result_byte);
                  error_total++;
               end
               if (rsp_payload.entry_number != want.entry_number) begin
                  $display("%0t entry_number: expected %0d, actual %0d", $time,
                           want.entry_number, rsp_payload.entry_number);
                  error_total++;
               end
               if (rsp_payload.final_of_run != want.final_of_run) begin
                  $display("%0t final_of_run: expected %0d, actual %0d", $time,
                           want.final_of_run, rsp_payload.final_of_run);
                  error_total++;
               end
            end
         end
      end
      mismatch_count <= error_total;
      results_outstanding <= expected_q.size();
   end

endmodule

/* verif/tb_key_value_config_text_parser_top.sv */
// Testbench top for the key/value text parser: builds text files, drives bytes, gives the verdict.
module tb_key_value_config_text_parser_top;

   import kvcfg_pkg::*;

   localparam int MAX_TEXT_LEN = DEF_MAX_TEXT_LEN;
   localparam int MAX_ENTRIES  = DEF_MAX_ENTRIES;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   int      mismatch_count;
   int      results_outstanding;

   req_type text_bytes[$];
   int      stall_mode = 0;
   int      stall_window = 0;
   logic [2:0] beat_phase = 3'd0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   key_value_config_text_parser_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   kv_parse_checker #(
      .MAX_TEXT_LEN (MAX_TEXT_LEN),
      .MAX_ENTRIES  (MAX_ENTRIES)
   ) checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_payload         (req_payload),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_payload         (rsp_payload),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   // hold rsp_ready on a randomly chosen pattern that is picked anew when its window runs out
   always @(posedge clock) begin
      beat_phase <= beat_phase + 3'd1;
      if (stall_window == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_window <= $urandom_range(8, 60);
      end else begin
         stall_window <= stall_window - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= beat_phase[2];
      endcase
   end

   function automatic logic [7:0] pick_name_char();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'(65 + r);
      if (r < 52) return 8'(97 + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] pick_value_char();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      return (v == "]") ? 8'h5C : v;
   endfunction

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 3))
         0: return 8'h20;
         1: return 8'h0A;
         2: return 8'h0D;
         default: return 8'h09;
      endcase
   endfunction

   function automatic int pick_length();
      if ($urandom_range(0, 29) == 0) return MAX_TEXT_LEN;
      return $urandom_range(0, 6);
   endfunction

   task automatic add_byte(input logic [7:0] b);
      req_type t;
      t.text_byte = b;
      t.end_of_text = 1'b0;
      text_bytes.push_back(t);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_space_run(input int max_len);
      repeat ($urandom_range(0, max_len)) add_byte(pick_space());
   endtask

   task automatic end_file();
      req_type t;
      t = text_bytes.pop_back();
      t.end_of_text = 1'b1;
      text_bytes.push_back(t);
   endtask

   task automatic add_entry_text(input int key_chars, input int data_chars);
      add_space_run(2);
      repeat (key_chars) add_byte(pick_name_char());
      add_space_run(1);
      add_byte("=");
      add_space_run(1);
      add_byte("[");
      add_space_run(1);
      repeat (data_chars) add_byte(pick_value_char());
      if (data_chars >= MAX_TEXT_LEN) begin
         repeat (2) add_byte(8'($urandom_range(0, 255)));
      end else begin
         add_byte("]");
         add_byte(8'($urandom_range(0, 255)));
      end
      add_byte(8'h0A);
   endtask

   task automatic add_random_file();
      int         shape;
      logic [7:0] v;
      repeat ($urandom_range(1, 5)) begin
         shape = $urandom_range(0, 9);
         if (shape < 7) begin
            add_entry_text(pick_length(), pick_length());
         end else if (shape == 7) begin
            add_byte("#");
            repeat ($urandom_range(0, 5)) begin
               v = 8'($urandom_range(0, 255));
               add_byte((v == 8'h0A) ? 8'h0B : v);
            end
            add_byte(8'h0A);
         end else if (shape == 8) begin
            repeat ($urandom_range(0, 3)) add_byte(pick_name_char());
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
            add_byte(8'h0A);
         end else begin
            add_byte(8'($urandom_range(0, 255)));
         end
      end
      // leave the last entry open at end of text now and then
      case ($urandom_range(0, 3))
         0: begin
            repeat ($urandom_range(0, 3)) add_byte(pick_name_char());
            add_text("=");
            add_space_run(1);
            add_byte("[");
            repeat ($urandom_range(0, 3)) add_byte(pick_value_char());
         end
         1: begin
            repeat ($urandom_range(1, 3)) add_byte(pick_name_char());
            if ($urandom_range(0, 1)) add_text(" =");
         end
         default: ;
      endcase
      end_file();
   endtask

   task automatic send_text(input req_type b);
      req_payload <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int burst_left;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;

      // directed: whitespace, comment, one name char of each kind, extreme bytes, syntax error, open ends
      add_byte(8'h20);
      add_byte(8'h09);
      add_byte(8'h0D);
      add_byte(8'h0A);
      add_text("# c");
      add_byte(8'h0A);
      add_text("Az_ = [");
      add_byte(8'hFF);
      add_text("]");
      add_byte(8'h00);
      add_text("a?x");
      add_byte(8'h0A);
      add_text("b =");
      end_file();
      add_text("=[");
      end_file();

      while (text_bytes.size() < 100) add_random_file();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      burst_left = $urandom_range(1, 30);
      foreach (text_bytes[i]) begin
         send_text(text_bytes[i]);
         burst_left--;
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = $urandom_range(1, 30);
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (results_outstanding != 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
